/* rtl/core/kmsd_pkg.sv */
// ---------------------------------------------------------------------------
// kmsd_pkg - shared constants for the key matrix scanner
// Matrix geometry, field widths and the packed layout of the stream beats.
// ---------------------------------------------------------------------------
package kmsd_pkg;

   localparam int ROWS      = 16;
   localparam int COLS      = 10;
   localparam int ROW_W     = 4;                     // bits to index a row
   localparam int COL_IDX_W = 4;                     // bits of query_col
   localparam int CNT_W     = 8;                     // pressed_count width
   localparam int ACC_W     = 9;                     // popcount accumulator
   localparam int QBITS_W   = 10;                    // query_row_bits width

   localparam logic [7:0] DEBOUNCE_RESET = 8'd5;

   // request beat: column_levels, query_row, query_col
   localparam int REQ_COL_LSB  = 0;
   localparam int REQ_QROW_LSB = 10;
   localparam int REQ_QCOL_LSB = 14;
   localparam int REQ_DATA_W   = 24;

   // response beat: next_row_select, settled, pressed_count,
   // query_row_bits, query_key_on
   localparam int RSP_DATA_W = 24;

   typedef logic [REQ_DATA_W-1:0] req_data_type;
   typedef logic [RSP_DATA_W-1:0] rsp_data_type;
   typedef logic [COLS-1:0]       row_bits_type;

endpackage

/* rtl/core/key_matrix_scan_debounce.sv */
// ---------------------------------------------------------------------------
// key_matrix_scan_debounce - keyboard matrix scanner with global debounce
// Compares each row reading against a raw-row store, reloads one debounce
// counter on any change, and copies raw rows into the stable matrix once the
// counter runs out at the end of a pass.
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ------------------------------------
//  req      in   req_tvalid/req_tready  req_tdata: column levels, query row/col
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata + rsp_tlast (end of pass)
//  csr      in   csr_valid/csr_ready    csr_data: debounce_scans
//
//  A beat steps through accept, update and finish; a beat that lets the
//  debounce counter expire adds a copy sweep over all 16 rows, one row per cycle
//  through the single raw-row read port and the popcount adder.
//  Reset clears both row stores, the row pointer and the pressed count, and
//  loads the debounce counter and setting with 5.
//  A finished result sits in the output register; the next beat is taken
//  while it waits, and only the finish step holds when that register is full.
//
module key_matrix_scan_debounce (
   input  logic                   clock,
   input  logic                   reset,
   // [9:0] column_levels, [13:10] query_row, [17:14] query_col, rest zero
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  kmsd_pkg::req_data_type req_tdata,
   // [3:0] next_row_select, [4] settled, [12:5] pressed_count,
   // [22:13] query_row_bits, [23] query_key_on
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output kmsd_pkg::rsp_data_type rsp_tdata,
   output logic                   rsp_tlast,   // pass_done
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);
   import kmsd_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_COPY,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [7:0]           deb_ff, deb_in;
   logic [7:0]           scans_ff, scans_in;
   row_bits_type         raw_ff [ROWS];
   row_bits_type         raw_in [ROWS];
   row_bits_type         stable_ff [ROWS];
   row_bits_type         stable_in [ROWS];
   row_bits_type         cols_ff, cols_in;
   logic [3:0]           qrow_ff, qrow_in;
   logic [COL_IDX_W-1:0] qcol_ff, qcol_in;
   logic                 pass_ff, pass_in;
   logic [ROW_W-1:0]     idx_ff, idx_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_data_type         rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Single read port on the raw store, shared by update and copy sweep.
   logic [ROW_W-1:0]     rd_addr;
   row_bits_type         raw_rd;
   logic [ACC_W-1:0]     acc_next;
   logic [7:0]           deb_upd;
   logic [7:0]           reload;
   row_bits_type         qrow_sel;
   logic [QBITS_W-1:0]   qbits;
   logic                 qkey;

   function automatic logic [ACC_W-1:0] popcount(input row_bits_type v);
      logic [ACC_W-1:0] n;
      n = '0;
      for (int i = 0; i < COLS; i++) begin
         n = n + ACC_W'(v[i]);
      end
      return n;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign rd_addr  = (state_ff == S_COPY) ? idx_ff : row_ff;
   assign raw_rd   = raw_ff[rd_addr];
   assign acc_next = acc_ff + popcount(raw_rd);
   // A setting of zero behaves as one pass.
   assign reload   = (scans_ff == 8'd0) ? 8'd1 : scans_ff;
   assign deb_upd  = (raw_rd != cols_ff) ? reload : deb_ff;

   always_comb begin
      qrow_sel = '0;
      if (int'(qrow_ff) < ROWS) begin
         qrow_sel = stable_ff[qrow_ff[ROW_W-1:0]];
      end
      qbits = QBITS_W'(qrow_sel);
      qkey  = 1'b0;
      if (int'(qcol_ff) < COLS) begin
         qkey = qrow_sel[qcol_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      deb_in       = deb_ff;
      scans_in     = scans_ff;
      raw_in       = raw_ff;
      stable_in    = stable_ff;
      cols_in      = cols_ff;
      qrow_in      = qrow_ff;
      qcol_in      = qcol_ff;
      pass_in      = pass_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      // drop the result once the sink takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         scans_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               // invert active-low levels into pressed bits
               cols_in  = ~req_tdata[REQ_COL_LSB +: COLS];
               qrow_in  = req_tdata[REQ_QROW_LSB +: 4];
               qcol_in  = req_tdata[REQ_QCOL_LSB +: COL_IDX_W];
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            raw_in[row_ff] = cols_ff;
            deb_in         = deb_upd;
            pass_in        = 1'b0;
            state_in       = S_FINISH;
            if (int'(row_ff) == ROWS - 1) begin
               pass_in = 1'b1;
               row_in  = '0;
               if (deb_upd != 8'd0) begin
                  deb_in = deb_upd - 8'd1;
                  if (deb_upd == 8'd1) begin
                     // counter expires: start the copy sweep
                     idx_in   = '0;
                     acc_in   = '0;
                     state_in = S_COPY;
                  end
               end
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         S_COPY: begin
            stable_in[idx_ff] = raw_rd;
            acc_in            = acc_next;
            if (int'(idx_ff) == ROWS - 1) begin
               count_in = (acc_next > ACC_W'(255)) ? 8'd255 : acc_next[CNT_W-1:0];
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + ROW_W'(1);
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = pass_ff;
               rsp_data_in  = {qkey, qbits, count_ff, (deb_ff == 8'd0),
                               4'(row_ff)};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         deb_ff       <= DEBOUNCE_RESET;
         scans_ff     <= DEBOUNCE_RESET;
         idx_ff       <= '0;
         acc_ff       <= '0;
         count_ff     <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         for (int i = 0; i < ROWS; i++) begin
            raw_ff[i]    <= '0;
            stable_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         deb_ff       <= deb_in;
         scans_ff     <= scans_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         raw_ff       <= raw_in;
         stable_ff    <= stable_in;
      end
      cols_ff     <= cols_in;
      qrow_ff     <= qrow_in;
      qcol_ff     <= qcol_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // copy only runs after the debounce counter has expired
   a_copy_settled: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |-> deb_ff == 8'd0)
      else $error("copy sweep with nonzero debounce counter");

   // sweep ends after the last row and goes to finish
   a_copy_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY && int'(idx_ff) == ROWS - 1) |=> state_ff == S_FINISH)
      else $error("copy sweep did not end at last row");

   // an accepted beat always enters the update step
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == S_UPDATE)
      else $error("accepted beat not updated");

   // a pass ends only with the row pointer wrapped to zero
   a_pass_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE && int'(row_ff) == ROWS - 1) |=> row_ff == '0 && pass_ff)
      else $error("row pointer failed to wrap at end of pass");
`endif

endmodule
